FILE: src/cacf_pkg.sv
package cacf_pkg;

    // Field and register widths fixed by the item layout
    localparam int SAMPLE_IN_W  = 24;
    localparam int SWEEP_W      = 1;
    localparam int IDX_W        = 12;
    localparam int THR_W        = 37;
    localparam int OUT_TDATA_W  = 56;
    localparam int TRAIN_W      = 6;
    localparam int GUARD_W      = 5;
    localparam int FACTOR_W     = 24;
    localparam int FRAC_BITS    = 16;
    localparam int HALF_W       = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int COUNT_W      = 6;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd2;

    // Limits and reset values
    localparam logic [TRAIN_W-1:0]  TRAIN_MAX     = 6'd32;
    localparam logic [GUARD_W-1:0]  GUARD_MAX     = 5'd16;
    localparam logic [TRAIN_W-1:0]  TRAIN_RESET   = 6'd16;
    localparam logic [GUARD_W-1:0]  GUARD_RESET   = 5'd4;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 24'd65536;
    localparam logic [COUNT_W-1:0]  MAX_RESULTS   = 6'd41;
    localparam logic [THR_W-1:0]    THR_MAX       = 37'h1F_FFFF_FFFF;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take input item, write ring
        logic win1;       // window bounds, first pass; also reads the cell under test
        logic win2;       // far end of lagging window, forward count
        logic win3;       // move shortfall to the other side
        logic rd_sum;     // issue one training read
        logic mul_lo;     // factor times low half of sum
        logic mul_hi;     // factor times high half of sum
        logic fin;        // add the two partial products
        logic emit;       // load result register, advance cell
        logic sweep_end;  // clear per-sweep counters
    } cacf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic due;        // a cell is ready to be reported
        logic last;       // current item closes the sweep
        logic rd_more;    // training reads still to issue
        logic out_free;   // result register can take a new item
    } cacf_sts_t;

endpackage

FILE: src/cacf_ram.sv
module cacf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/cacf_ctrl.sv
module cacf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output cacf_pkg::cacf_cmd_t cmd,
    input  cacf_pkg::cacf_sts_t sts
);

    import cacf_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_WIN1  = 4'd2;
    localparam logic [3:0] ST_WIN2  = 4'd3;
    localparam logic [3:0] ST_WIN3  = 4'd4;
    localparam logic [3:0] ST_READ  = 4'd5;
    localparam logic [3:0] ST_MLO   = 4'd6;
    localparam logic [3:0] ST_MHI   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.due) begin
                    state_next = ST_WIN1;
                end else begin
                    cmd.sweep_end = sts.last;
                    state_next    = ST_IDLE;
                end
            end
            ST_WIN1: begin
                cmd.win1   = 1'b1;
                state_next = ST_WIN2;
            end
            ST_WIN2: begin
                cmd.win2   = 1'b1;
                state_next = ST_WIN3;
            end
            ST_WIN3: begin
                cmd.win3   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                // the pass through ST_READ that issues no read lets the last read's data land in the sum
                if (sts.rd_more) begin
                    cmd.rd_sum = 1'b1;
                end else begin
                    state_next = ST_MLO;
                end
            end
            ST_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

FILE: src/cacf_dp.sv
module cacf_dp #(
    parameter int MAX_CELLS   = 4096,
    parameter int RING_DEPTH  = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cacf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cacf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [cacf_pkg::SAMPLE_IN_W-1:0]    s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cacf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    input  cacf_pkg::cacf_cmd_t                 cmd,
    output cacf_pkg::cacf_sts_t                 sts
);

    import cacf_pkg::*;

    localparam int CW     = $clog2(MAX_CELLS);
    localparam int NW     = CW + 1;
    localparam int PW     = CW + 2;
    localparam int AW     = $clog2(RING_DEPTH);
    localparam int SUMW   = SAMPLE_BITS + 5;
    localparam int LOW    = (SUMW + 1) / 2;
    localparam int HIW    = SUMW - LOW;
    localparam int PLW    = FACTOR_W + LOW;
    localparam int PRODW  = FACTOR_W + SUMW;
    localparam int SHW    = PRODW - FRAC_BITS;
    localparam int CMPW   = (SHW > THR_W) ? SHW : THR_W;

    // ring address arithmetic, offsets always below the depth
    function automatic logic [AW-1:0] addr_fwd(input logic [AW-1:0] a, input logic [AW-1:0] d);
        logic [AW:0] t;
        t = {1'b0, a} + {1'b0, d};
        if (t >= (AW+1)'(RING_DEPTH)) begin
            t = t - (AW+1)'(RING_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_back(input logic [AW-1:0] a, input logic [AW-1:0] d);
        logic [AW:0] t;
        t = {1'b0, a} + (AW+1)'(RING_DEPTH) - {1'b0, d};
        if (t >= (AW+1)'(RING_DEPTH)) begin
            t = t - (AW+1)'(RING_DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // configuration
    logic [TRAIN_W-1:0]  train_reg;
    logic [GUARD_W-1:0]  guard_reg;
    logic [FACTOR_W-1:0] factor_reg;

    // sweep bookkeeping
    logic [CW-1:0] rcv_reg;
    logic [AW-1:0] wr_ptr_reg;
    logic [CW-1:0] cur_reg;
    logic          last_reg;
    logic [NW-1:0] next_reg;
    logic [AW-1:0] next_addr_reg;
    logic [COUNT_W-1:0] count_reg;

    // window
    logic signed [PW-1:0] fs_reg, fe_reg, rs_reg, re_reg;
    logic [AW-1:0]        fs_addr_reg, rs_addr_reg;
    logic [HALF_W-1:0]    nf_reg;

    // arithmetic
    logic [SUMW-1:0]        sum_reg;
    logic                   sum_pend_reg;
    logic                   cut_pend_reg;
    logic [SAMPLE_BITS-1:0] cut_reg;
    logic [PLW-1:0]         prod_reg;
    logic [PRODW-1:0]       acc_reg;

    // result register
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_index_reg;
    logic [THR_W-1:0] m_thr_reg;
    logic             m_det_reg;
    logic             m_last_reg;

    logic [HALF_W-1:0] ht, hg, reach;
    logic signed [PW-1:0] ht_s, hg_s, i_pos, n_pos;
    logic signed [PW-1:0] fs_raw, fe_raw, rs_raw, re_raw, re_ext, fs_ext;
    logic [HALF_W-1:0] nr, d_rev, d_fwd;
    logic fwd_more, rev_more, in_last;
    logic [SHW-1:0]   shifted;
    logic [CMPW-1:0]  sh_ext, thr_sat;
    logic [THR_W-1:0] thr_next;
    logic             det_next;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;

    assign ht    = HALF_W'(train_reg >> 1);
    assign hg    = HALF_W'(guard_reg >> 1);
    assign reach = hg + HALF_W'(train_reg);
    assign ht_s  = $signed(PW'(ht));
    assign hg_s  = $signed(PW'(hg));
    assign i_pos = $signed(PW'(next_reg));
    assign n_pos = $signed(PW'(cur_reg)) + $signed(PW'(1));

    assign fs_raw = i_pos - hg_s - ht_s;
    assign fe_raw = i_pos - hg_s;
    assign rs_raw = i_pos + hg_s + $signed(PW'(1));
    assign re_raw = rs_reg + ht_s;

    assign nr     = HALF_W'(re_reg - rs_reg);
    assign d_rev  = ht - nf_reg;
    assign d_fwd  = ht - nr;
    assign re_ext = re_reg + $signed(PW'(d_rev));
    assign fs_ext = fs_reg - $signed(PW'(d_fwd));

    assign fwd_more = (fs_reg < fe_reg);
    assign rev_more = (rs_reg < re_reg);
    assign in_last  = s_tlast || (rcv_reg == CW'(MAX_CELLS - 1));

    assign shifted  = acc_reg[PRODW-1:FRAC_BITS];
    assign sh_ext   = CMPW'(shifted);
    assign thr_sat  = (sh_ext > CMPW'(THR_MAX)) ? CMPW'(THR_MAX) : sh_ext;
    assign thr_next = thr_sat[THR_W-1:0];
    assign det_next = THR_W'(cut_reg) > thr_next;

    assign ram_rd_en   = cmd.win1 || cmd.rd_sum;
    assign ram_rd_addr = cmd.win1 ? next_addr_reg : (fwd_more ? fs_addr_reg : rs_addr_reg);

    cacf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (cmd.accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (SAMPLE_BITS'(s_tdata)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rdata)
    );

    // configuration registers, train and guard lengths saturated on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            train_reg  <= TRAIN_RESET;
            guard_reg  <= GUARD_RESET;
            factor_reg <= FACTOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRAIN:  train_reg  <= (cfg_wdata[TRAIN_W-1:0] > TRAIN_MAX) ?
                                          TRAIN_MAX : cfg_wdata[TRAIN_W-1:0];
                CFG_GUARD:  guard_reg  <= (cfg_wdata[GUARD_W-1:0] > GUARD_MAX) ?
                                          GUARD_MAX : cfg_wdata[GUARD_W-1:0];
                CFG_FACTOR: factor_reg <= cfg_wdata[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // counters and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcv_reg       <= '0;
            wr_ptr_reg    <= '0;
            cur_reg       <= '0;
            last_reg      <= 1'b0;
            next_reg      <= '0;
            next_addr_reg <= '0;
            count_reg     <= '0;
            sum_pend_reg  <= 1'b0;
            cut_pend_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            sum_pend_reg <= cmd.rd_sum;
            cut_pend_reg <= cmd.win1;
            if (cmd.accept) begin
                cur_reg   <= rcv_reg;
                last_reg  <= in_last;
                count_reg <= '0;
                if (in_last) begin
                    rcv_reg    <= '0;
                    wr_ptr_reg <= '0;
                end else begin
                    rcv_reg    <= rcv_reg + CW'(1);
                    wr_ptr_reg <= addr_fwd(wr_ptr_reg, AW'(1));
                end
            end
            if (cmd.emit) begin
                next_reg      <= next_reg + NW'(1);
                next_addr_reg <= addr_fwd(next_addr_reg, AW'(1));
                count_reg     <= count_reg + COUNT_W'(1);
            end
            if (cmd.sweep_end) begin
                next_reg      <= '0;
                next_addr_reg <= '0;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // window bounds, sums and products
    always_ff @(posedge aclk) begin
        if (cmd.win1) begin
            fs_reg      <= fs_raw[PW-1] ? '0 : fs_raw;
            fe_reg      <= fe_raw[PW-1] ? '0 : fe_raw;
            rs_reg      <= (rs_raw > n_pos) ? n_pos : rs_raw;
            fs_addr_reg <= fs_raw[PW-1] ? '0 : addr_back(next_addr_reg, AW'(hg + ht));
            rs_addr_reg <= addr_fwd(next_addr_reg, AW'(hg + HALF_W'(1)));
            sum_reg     <= '0;
        end
        if (cmd.win2) begin
            re_reg <= (re_raw > n_pos) ? n_pos : re_raw;
            nf_reg <= HALF_W'(fe_reg - fs_reg);
        end
        if (cmd.win3) begin
            if (nf_reg < nr) begin
                re_reg <= (re_ext > n_pos) ? n_pos : re_ext;
            end else if (fs_ext[PW-1]) begin
                fs_reg      <= '0;
                fs_addr_reg <= '0;
            end else begin
                fs_reg      <= fs_ext;
                fs_addr_reg <= addr_back(fs_addr_reg, AW'(d_fwd));
            end
        end
        if (cmd.rd_sum) begin
            if (fwd_more) begin
                fs_reg      <= fs_reg + $signed(PW'(1));
                fs_addr_reg <= addr_fwd(fs_addr_reg, AW'(1));
            end else begin
                rs_reg      <= rs_reg + $signed(PW'(1));
                rs_addr_reg <= addr_fwd(rs_addr_reg, AW'(1));
            end
        end
        if (sum_pend_reg) begin
            sum_reg <= sum_reg + SUMW'(ram_rdata);
        end
        if (cut_pend_reg) begin
            cut_reg <= ram_rdata;
        end
        if (cmd.mul_lo) begin
            prod_reg <= PLW'(factor_reg) * PLW'(sum_reg[LOW-1:0]);
        end
        if (cmd.mul_hi) begin
            acc_reg  <= PRODW'(prod_reg);
            prod_reg <= PLW'(factor_reg) * PLW'(sum_reg[SUMW-1:SUMW-HIW]);
        end
        if (cmd.fin) begin
            acc_reg <= acc_reg + (PRODW'(prod_reg) << LOW);
        end
        if (cmd.emit) begin
            m_index_reg <= IDX_W'(next_reg);
            m_thr_reg   <= thr_next;
            m_det_reg   <= det_next;
            m_last_reg  <= last_reg && (next_reg == NW'(cur_reg));
        end
    end

    always_comb begin
        sts          = '0;
        sts.last     = last_reg;
        sts.rd_more  = fwd_more || rev_more;
        sts.out_free = !m_valid_reg || m_tready;
        if (count_reg < MAX_RESULTS) begin
            if (last_reg) begin
                sts.due = (next_reg <= NW'(cur_reg));
            end else begin
                sts.due = ((NW+1)'(next_reg) + (NW+1)'(reach)) <= (NW+1)'(cur_reg);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({m_det_reg, m_thr_reg, m_index_reg});
    assign m_tlast  = m_last_reg;

endmodule

FILE: src/cell_averaging_cfar_1d.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata = power_sample[23:0]; s_tlast = sweep_last
// m_       out  m_tvalid/m_tready  m_tdata = cell_index, threshold, detected; m_tlast
// cfg_     in   cfg_wr_en          cfg_index selects register, cfg_wdata carries value
//
// An input item is accepted in ST_IDLE, then ST_CHECK decides whether a cell is due.
// Each reported cell takes one ring read per training cell on the single memory read
// port, three window steps and two partial products, each step done in turn.
// Input is taken only between items; the result register lets the next cell be
// worked on while the last result waits. aresetn is synchronous, active low; the
// sample ring is not cleared, only cells of the current sweep are ever read.
module cell_averaging_cfar_1d #(
    parameter int MAX_CELLS   = 4096,
    parameter int RING_DEPTH  = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [cacf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cacf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cacf_pkg::SAMPLE_IN_W-1:0] s_tdata,   // [23:0] power_sample
    input  logic                             s_tlast,   // sweep_last
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cacf_pkg::OUT_TDATA_W-1:0] m_tdata,   // [11:0] cell_index, [48:12] threshold,
                                                        // [49] detected, [55:50] zero
    output logic                             m_tlast    // result_last
);

    import cacf_pkg::*;

    cacf_cmd_t cmd;
    cacf_sts_t sts;

    // sequencer: one item in, then each due cell in turn
    cacf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // sample ring, window arithmetic, threshold and result register
    cacf_dp #(
        .MAX_CELLS   (MAX_CELLS),
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    // the sequencer drives at most one datapath step per cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.win1, cmd.win2, cmd.win3, cmd.rd_sum,
                  cmd.mul_lo, cmd.mul_hi, cmd.fin, cmd.emit, cmd.sweep_end}))
        else $error("more than one datapath command in a cycle");

    // a result is never loaded over one still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result register overwritten");

    // an accepted item is processed before the next is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // training reads only while the window has cells left
    a_rd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_sum |-> sts.rd_more)
        else $error("training read beyond window");
`endif

endmodule
